// ===== hdl/lsb_stego_stream_decoder_top_defines.svh =====
// assertion macros for the stego stream decoder
`ifndef LSB_STEGO_STREAM_DECODER_TOP_DEFINES_SVH
`define LSB_STEGO_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define LSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsd check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define LSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsd check failed");

`endif

// ===== hdl/lsd_pkg.sv =====
`default_nettype none

package lsd_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_HEADER_SKIP     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAGIC_FIRST     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAGIC_SECOND    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_EXTENSION_CHARS = 2'd3;

  // reset values of the registers
  localparam logic [7:0] HEADER_SKIP_RST     = 8'd54;
  localparam logic [7:0] MAGIC_FIRST_RST     = 8'd35;
  localparam logic [7:0] MAGIC_SECOND_RST    = 8'd42;
  localparam logic [3:0] EXTENSION_CHARS_RST = 4'd4;

  // record kinds
  localparam logic [2:0] KIND_EXT_SIZE = 3'd0;
  localparam logic [2:0] KIND_EXT_CHAR = 3'd1;
  localparam logic [2:0] KIND_FILE_SIZE = 3'd2;
  localparam logic [2:0] KIND_DATA     = 3'd3;
  localparam logic [2:0] KIND_MISMATCH = 3'd4;

  // configuration as seen by the parser
  typedef struct packed {
    logic [7:0] header_skip;
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [3:0] extension_chars;
  } lsd_cfg_t;

  // one parser step result
  typedef struct packed {
    logic        emit;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } lsd_rec_t;

endpackage

`default_nettype wire

// ===== hdl/lsd_cfg_regs.sv =====
`default_nettype none

module lsd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lsd_pkg::CfgDataW-1:0] cfg_data_i,
  output lsd_pkg::lsd_cfg_t                 cfg_o
);

  lsd_pkg::lsd_cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lsd_pkg::REG_HEADER_SKIP:     cfg_d.header_skip     = cfg_data_i;
        lsd_pkg::REG_MAGIC_FIRST:     cfg_d.magic_first     = cfg_data_i;
        lsd_pkg::REG_MAGIC_SECOND:    cfg_d.magic_second    = cfg_data_i;
        lsd_pkg::REG_EXTENSION_CHARS: cfg_d.extension_chars = cfg_data_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_skip     <= lsd_pkg::HEADER_SKIP_RST;
      cfg_q.magic_first     <= lsd_pkg::MAGIC_FIRST_RST;
      cfg_q.magic_second    <= lsd_pkg::MAGIC_SECOND_RST;
      cfg_q.extension_chars <= lsd_pkg::EXTENSION_CHARS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/lsd_parser.sv =====
`default_nettype none

module lsd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsd_pkg::lsd_cfg_t cfg_i,
  input  wire logic              step_i,
  input  wire logic              bit_i,
  input  wire logic              start_i,
  output lsd_pkg::lsd_rec_t      rec_o
);

  typedef enum logic [7:0] {
    PH_SKIP    = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_EXTSIZE = 8'b0000_0100,
    PH_EXTCHAR = 8'b0000_1000,
    PH_FSIZE   = 8'b0001_0000,
    PH_DATA    = 8'b0010_0000,
    PH_IDLE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } lsd_phase_e;

  localparam logic [3:0] MagicBytes = 4'd2;
  localparam logic [3:0] MaxExt     = 4'd8;

  lsd_phase_e  phase_q, phase_d, ph;
  logic [7:0]  hc_q, hc_d, hc;
  logic [4:0]  bc_q, bc_d, bc;
  logic [30:0] acc_q, acc_d, acc;
  logic [3:0]  ic_q, ic_d, ic, ic_next;
  logic [31:0] br_q, br_d, br, br_next;
  logic [31:0] full, v;
  logic [7:0]  expect_byte;
  logic [3:0]  ext_cnt;
  logic        run, need32, done;

  // extension count saturates at eight
  assign ext_cnt = (cfg_i.extension_chars > MaxExt) ? MaxExt : cfg_i.extension_chars;

  // one byte of parsing
  always_comb begin
    ph  = phase_q;
    hc  = hc_q;
    bc  = bc_q;
    acc = acc_q;
    ic  = ic_q;
    br  = br_q;
    // image start clears the parse state for this very byte
    if (start_i) begin
      ph  = PH_SKIP;
      hc  = 8'd0;
      bc  = 5'd0;
      acc = 31'd0;
      ic  = 4'd0;
      br  = 32'd0;
    end

    phase_d = ph;
    hc_d    = hc;
    bc_d    = bc;
    acc_d   = acc;
    ic_d    = ic;
    br_d    = br;
    run     = 1'b1;
    rec_o   = '0;

    // header skip
    if (ph == PH_SKIP) begin
      if (hc < cfg_i.header_skip) begin
        hc_d = hc + 8'd1;
        run  = 1'b0;
      end else begin
        ph      = PH_MAGIC;
        phase_d = PH_MAGIC;
      end
    end
    if (ph == PH_IDLE || ph == PH_ERROR) begin
      run = 1'b0;
    end

    need32      = (ph == PH_EXTSIZE) || (ph == PH_FSIZE);
    full        = {acc, bit_i};
    done        = need32 ? (bc == 5'd31) : (bc >= 5'd7);
    v           = need32 ? full : {24'd0, full[7:0]};
    expect_byte = (ic == 4'd0) ? cfg_i.magic_first : cfg_i.magic_second;
    ic_next     = ic + 4'd1;
    br_next     = (br != 32'd0) ? (br - 32'd1) : br;
    rec_o.value = v;

    if (run) begin
      if (!done) begin
        // still gathering bits
        acc_d = full[30:0];
        bc_d  = bc + 5'd1;
      end else begin
        acc_d = 31'd0;
        bc_d  = 5'd0;
        case (ph)
          PH_MAGIC: begin
            if (v[7:0] != expect_byte) begin
              phase_d    = PH_ERROR;
              ic_d       = 4'd0;
              rec_o.emit = 1'b1;
              rec_o.kind = lsd_pkg::KIND_MISMATCH;
              rec_o.last = 1'b1;
            end else if (ic_next >= MagicBytes) begin
              ic_d    = 4'd0;
              phase_d = PH_EXTSIZE;
            end else begin
              ic_d = ic_next;
            end
          end
          PH_EXTSIZE: begin
            phase_d    = (ext_cnt == 4'd0) ? PH_FSIZE : PH_EXTCHAR;
            ic_d       = 4'd0;
            rec_o.emit = 1'b1;
            rec_o.kind = lsd_pkg::KIND_EXT_SIZE;
          end
          PH_EXTCHAR: begin
            if (ic_next >= ext_cnt) begin
              ic_d    = 4'd0;
              phase_d = PH_FSIZE;
            end else begin
              ic_d = ic_next;
            end
            rec_o.emit = 1'b1;
            rec_o.kind = lsd_pkg::KIND_EXT_CHAR;
          end
          PH_FSIZE: begin
            br_d       = v;
            phase_d    = (v == 32'd0) ? PH_IDLE : PH_DATA;
            rec_o.emit = 1'b1;
            rec_o.kind = lsd_pkg::KIND_FILE_SIZE;
            rec_o.last = (v == 32'd0);
          end
          PH_DATA: begin
            br_d       = br_next;
            rec_o.emit = 1'b1;
            rec_o.kind = lsd_pkg::KIND_DATA;
            if (br_next == 32'd0) begin
              phase_d    = PH_IDLE;
              rec_o.last = 1'b1;
            end
          end
          default: begin
            rec_o.emit = 1'b0;
          end
        endcase
      end
    end
  end

  // parse state, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      hc_q    <= 8'd0;
      bc_q    <= 5'd0;
      acc_q   <= 31'd0;
      ic_q    <= 4'd0;
      br_q    <= 32'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      bc_q    <= bc_d;
      acc_q   <= acc_d;
      ic_q    <= ic_d;
      br_q    <= br_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lsb_stego_stream_decoder_top.sv =====
// a result word passes from the input register through the parser into the result register
// throughput: one image word per cycle while the result side is not stalled, set by the
//   single parse step between the input register and the result register
// reset: asynchronous active low; configuration registers return to their defaults and the
//   parser restarts in the header skip phase
`default_nettype none

module lsb_stego_stream_decoder_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [7:0]                   image_byte_i,
  input  wire logic                         image_start_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [2:0]                   record_kind_o,
  output      logic [31:0]                  record_value_o,
  output      logic                         record_last_o
);

  lsd_pkg::lsd_cfg_t cfg;
  lsd_pkg::lsd_rec_t rec;

  logic        in_valid_q, in_bit_q, in_start_q;
  logic        out_valid_q, out_last_q;
  logic [2:0]  out_kind_q;
  logic [31:0] out_value_q;
  logic        advance, take, in_accept;

  // handshake: the input register doubles as the skid stage
  assign advance    = !out_valid_q || !out_stall_i;
  assign take       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  lsd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lsd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (take),
    .bit_i   (in_bit_q),
    .start_i (in_start_q),
    .rec_o   (rec)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_bit_q   <= image_byte_i[0];
      in_start_q <= image_start_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= take && rec.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && rec.emit) begin
      out_kind_q  <= rec.kind;
      out_value_q <= rec.value;
      out_last_q  <= rec.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = out_kind_q;
  assign record_value_o = out_value_q;
  assign record_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/lsd_checker.sv =====
`default_nettype none
`include "lsb_stego_stream_decoder_top_defines.svh"

module lsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_i,
  input wire logic        out_valid_i,
  input wire logic        out_stall_i,
  input wire logic [2:0]  record_kind_i,
  input wire logic [31:0] record_value_i,
  input wire logic        record_last_i
);

  logic [35:0] rec_word;
  logic        err_word;
  logic        byte_word;

  // whole result word, and the kinds that carry only a byte
  assign rec_word  = {record_kind_i, record_value_i, record_last_i};
  assign err_word  = out_valid_i && (record_kind_i == lsd_pkg::KIND_MISMATCH);
  assign byte_word = out_valid_i && (record_kind_i inside {lsd_pkg::KIND_EXT_CHAR,
                                                           lsd_pkg::KIND_DATA,
                                                           lsd_pkg::KIND_MISMATCH});

  // a stalled result word holds
  `LSD_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(rec_word))

  // the input side stalls only behind a stuck result word
  `LSD_ASSERT_IMPL(a_stall_cause, in_stall_i, out_valid_i && out_stall_i)

  // a magic mismatch always closes the image
  `LSD_ASSERT_IMPL(a_err_last, err_word, record_last_i)

  // characters, data bytes and magic mismatch bytes carry only a byte
  `LSD_ASSERT_IMPL(a_byte_value, byte_word, record_value_i[31:8] == 24'd0)

endmodule

bind lsb_stego_stream_decoder_top lsd_checker u_lsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .record_kind_i  (record_kind_o),
  .record_value_i (record_value_o),
  .record_last_i  (record_last_o)
);

`default_nettype wire

// ===== tb/sv/lsd_record_checker.sv =====
module lsd_record_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   image_byte_i,
  input  logic                         image_start_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [2:0]                   record_kind_i,
  input  logic [31:0]                  record_value_i,
  input  logic                         record_last_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  records_waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAGIC_LEN = 2;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned EXT_LIMIT = 8;

  typedef enum logic [2:0] {
    ST_SKIP, ST_MAGIC, ST_EXT_SIZE, ST_EXT_CHAR, ST_FILE_SIZE, ST_DATA, ST_DONE, ST_ERROR
  } parse_phase_e;

  // register copies
  logic [7:0] skip_len;
  logic [7:0] magic_a;
  logic [7:0] magic_b;
  logic [3:0] ext_raw;

  // parser state
  parse_phase_e phase;
  int unsigned  hdr_seen;
  int unsigned  bits_taken;
  int unsigned  items_seen;
  logic [31:0]  bit_shift;
  logic [31:0]  bytes_left;

  lsd_pkg::lsd_rec_t expected_records[$];
  int unsigned       fails = 0;

  function automatic void clear_parse();
    phase      = ST_SKIP;
    hdr_seen   = 0;
    bits_taken = 0;
    items_seen = 0;
    bit_shift  = '0;
    bytes_left = '0;
  endfunction

  // one image word through the parser, returns the record it yields if any
  function automatic lsd_pkg::lsd_rec_t decode_image_byte(input logic [7:0] pix,
                                                          input logic restart);
    lsd_pkg::lsd_rec_t rec;
    int unsigned       width;
    int unsigned       n_ext;
    logic [31:0]       shifted;
    logic [31:0]       word;
    logic [7:0]        want;
    rec   = '0;
    n_ext = (ext_raw > EXT_LIMIT) ? EXT_LIMIT : ext_raw;
    if (restart) begin
      clear_parse();
    end
    if (phase == ST_SKIP) begin
      if (hdr_seen < skip_len) begin
        hdr_seen++;
        return rec;
      end
      phase = ST_MAGIC;
    end
    if (phase == ST_DONE || phase == ST_ERROR) begin
      return rec;
    end
    // gather hidden bits, msb first
    width   = (phase == ST_EXT_SIZE || phase == ST_FILE_SIZE) ? WORD_BITS : BYTE_BITS;
    shifted = {bit_shift[30:0], pix[0]};
    if (bits_taken + 1 < width) begin
      bit_shift = shifted;
      bits_taken++;
      return rec;
    end
    bit_shift  = '0;
    bits_taken = 0;
    word       = (width == BYTE_BITS) ? {24'd0, shifted[7:0]} : shifted;
    rec.emit   = 1'b1;
    rec.value  = word;
    rec.last   = 1'b0;
    case (phase)
      ST_MAGIC: begin
        want = (items_seen == 0) ? magic_a : magic_b;
        if (word != {24'd0, want}) begin
          phase      = ST_ERROR;
          items_seen = 0;
          rec.kind   = lsd_pkg::KIND_MISMATCH;
          rec.last   = 1'b1;
          return rec;
        end
        items_seen++;
        if (items_seen >= MAGIC_LEN) begin
          items_seen = 0;
          phase      = ST_EXT_SIZE;
        end
        rec.emit = 1'b0;
      end
      ST_EXT_SIZE: begin
        phase      = (n_ext == 0) ? ST_FILE_SIZE : ST_EXT_CHAR;
        items_seen = 0;
        rec.kind   = lsd_pkg::KIND_EXT_SIZE;
      end
      ST_EXT_CHAR: begin
        items_seen++;
        if (items_seen >= n_ext) begin
          items_seen = 0;
          phase      = ST_FILE_SIZE;
        end
        rec.kind = lsd_pkg::KIND_EXT_CHAR;
      end
      ST_FILE_SIZE: begin
        bytes_left = word;
        phase      = (word == 0) ? ST_DONE : ST_DATA;
        rec.kind   = lsd_pkg::KIND_FILE_SIZE;
        rec.last   = (word == 0);
      end
      default: begin
        if (bytes_left != 0) begin
          bytes_left--;
        end
        if (bytes_left == 0) begin
          phase    = ST_DONE;
          rec.last = 1'b1;
        end
        rec.kind = lsd_pkg::KIND_DATA;
      end
    endcase
    return rec;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    lsd_pkg::lsd_rec_t rec;
    lsd_pkg::lsd_rec_t want;
    if (!rst_ni) begin
      skip_len = lsd_pkg::HEADER_SKIP_RST;
      magic_a  = lsd_pkg::MAGIC_FIRST_RST;
      magic_b  = lsd_pkg::MAGIC_SECOND_RST;
      ext_raw  = lsd_pkg::EXTENSION_CHARS_RST;
      clear_parse();
      expected_records.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lsd_pkg::REG_HEADER_SKIP:     skip_len = cfg_data_i[7:0];
          lsd_pkg::REG_MAGIC_FIRST:     magic_a  = cfg_data_i[7:0];
          lsd_pkg::REG_MAGIC_SECOND:    magic_b  = cfg_data_i[7:0];
          lsd_pkg::REG_EXTENSION_CHARS: ext_raw  = cfg_data_i[3:0];
          default: ;
        endcase
      end
      // accepted image word
      if (in_valid_i && !in_stall_i) begin
        rec = decode_image_byte(image_byte_i, image_start_i);
        if (rec.emit) begin
          expected_records.push_back(rec);
        end
      end
      // accepted result word
      if (out_valid_i && !out_stall_i) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected result word, got kind %0d value %h last %b",
                   $time, record_kind_i, record_value_i, record_last_i);
          fails++;
        end else begin
          want = expected_records.pop_front();
          if (record_kind_i !== want.kind) begin
            $display("%0t: record kind mismatch, expected %0d got %0d",
                     $time, want.kind, record_kind_i);
            fails++;
          end
          if (record_value_i !== want.value) begin
            $display("%0t: record value mismatch, expected %h got %h",
                     $time, want.value, record_value_i);
            fails++;
          end
          if (record_last_i !== want.last) begin
            $display("%0t: record last mismatch, expected %b got %b",
                     $time, want.last, record_last_i);
            fails++;
          end
        end
      end
    end
    fail_count_o      <= fails;
    records_waiting_o <= expected_records.size();
  end

endmodule

// ===== tb/sv/tb_lsb_stego_stream_decoder_top.sv =====
module tb_lsb_stego_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned WHOLE_IMAGE = 32'hFFFF_FFFF;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned EXT_LIMIT   = 8;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [lsd_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [lsd_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic [7:0]                   image_byte_i  = '0;
  logic                         image_start_i = 1'b0;
  logic                         out_stall_i   = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [2:0]                   record_kind_o;
  logic [31:0]                  record_value_o;
  logic                         record_last_o;

  int unsigned fail_count;
  int unsigned records_waiting;

  // stimulus side view of the registers
  int unsigned cur_skip;
  logic [7:0]  cur_m0;
  logic [7:0]  cur_m1;
  int unsigned cur_ext;

  bit          hidden_q[$];
  int unsigned parsed_bytes = 0;
  int unsigned sender_calm  = 0;
  int unsigned stall_left   = 0;
  int unsigned calm_left    = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  lsb_stego_stream_decoder_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .image_byte_i   (image_byte_i),
    .image_start_i  (image_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .record_value_o (record_value_o),
    .record_last_o  (record_last_o)
  );

  lsd_record_checker u_record_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .image_byte_i      (image_byte_i),
    .image_start_i     (image_start_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .record_kind_i     (record_kind_o),
    .record_value_i    (record_value_o),
    .record_last_i     (record_last_o),
    .fail_count_o      (fail_count),
    .records_waiting_o (records_waiting)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic logic [31:0] any_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic void append_field(input logic [31:0] v, input int unsigned nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      hidden_q.push_back(v[i]);
    end
  endfunction

  // hidden bit stream of one image; stops after a magic byte that will fail
  function automatic void build_image(input logic [7:0] ma, input logic [7:0] mb,
                                      input logic [31:0] ext_size,
                                      input logic [31:0] fsize, input int unsigned n_data);
    hidden_q.delete();
    append_field({24'd0, ma}, 8);
    if (ma != cur_m0) return;
    append_field({24'd0, mb}, 8);
    if (mb != cur_m1) return;
    append_field(ext_size, 32);
    for (int unsigned i = 0; i < cur_ext; i++) begin
      append_field({24'd0, any_byte()}, 8);
    end
    append_field(fsize, 32);
    for (int unsigned i = 0; i < n_data; i++) begin
      append_field({24'd0, any_byte()}, 8);
    end
  endfunction

  // one image word, after a random gap
  task automatic push_byte(input logic [7:0] pix, input logic restart);
    int unsigned gap;
    gap = 0;
    if (sender_calm != 0) begin
      sender_calm--;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 99) == 0) begin
        sender_calm = $urandom_range(30, 120);
      end
    end
    if (gap != 0) begin
      in_valid_i    <= 1'b0;
      image_byte_i  <= any_byte();
      image_start_i <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    image_byte_i  <= pix;
    image_start_i <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // header words then the hidden bits, cut short if asked
  task automatic send_image(input logic with_start, input int unsigned cut);
    int unsigned total;
    logic [7:0]  pix;
    total = cur_skip + hidden_q.size();
    if (cut > total) cut = total;
    for (int unsigned n = 0; n < cut; n++) begin
      pix = any_byte();
      if (n >= cur_skip) begin
        pix[0] = hidden_q[n - cur_skip];
      end
      push_byte(pix, with_start && (n == 0));
      parsed_bytes++;
    end
    hidden_q.delete();
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) push_byte(any_byte(), 1'b0);
  endtask

  // hold the sender until every result has arrived, plus the pipeline depth
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (records_waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] skip, input logic [7:0] m0,
                            input logic [7:0] m1, input logic [7:0] ext);
    logic [lsd_pkg::CfgIdxW-1:0]  idx[4];
    logic [lsd_pkg::CfgDataW-1:0] vals[4];
    drain();
    idx  = '{lsd_pkg::REG_HEADER_SKIP, lsd_pkg::REG_MAGIC_FIRST, lsd_pkg::REG_MAGIC_SECOND,
             lsd_pkg::REG_EXTENSION_CHARS};
    vals = '{skip, m0, m1, ext};
    for (int r = 0; r < 4; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[r];
      cfg_data_i <= vals[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_skip = skip;
    cur_m0   = m0;
    cur_m1   = m1;
    cur_ext  = (ext[3:0] > EXT_LIMIT) ? EXT_LIMIT : ext[3:0];
  endtask

  // well-formed images mostly, some with bad magic, truncated or trailed by noise
  task automatic random_image();
    int unsigned r;
    int unsigned n_data;
    int unsigned cut;
    logic [7:0]  flip;
    logic [7:0]  ma;
    logic [7:0]  mb;
    logic [31:0] fsize;
    r    = $urandom_range(0, 99);
    flip = 8'($urandom_range(1, 255));
    ma   = cur_m0;
    mb   = cur_m1;
    if (r < 7) begin
      ma = cur_m0 ^ flip;
    end else if (r < 14) begin
      mb = cur_m1 ^ flip;
    end
    case ($urandom_range(0, 9))
      0: begin
        fsize  = $urandom;
        n_data = $urandom_range(0, 6);
      end
      1, 2: begin
        fsize  = $urandom_range(5, 14);
        n_data = fsize;
      end
      default: begin
        fsize  = $urandom_range(0, 4);
        n_data = fsize;
      end
    endcase
    build_image(ma, mb, any_word(), fsize, n_data);
    cut = WHOLE_IMAGE;
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, cur_skip + hidden_q.size());
    end
    send_image(1'b1, cut);
    if ($urandom_range(0, 4) == 0) begin
      push_noise($urandom_range(1, 6));
    end
    if ($urandom_range(0, 11) == 0) begin
      drain();
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      calm_left   <= 0;
    end else if (calm_left != 0) begin
      out_stall_i <= 1'b0;
      calm_left   <= calm_left - 1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 199) == 0) begin
        calm_left <= $urandom_range(50, 150);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left <= gap_len();
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lsb_stego_stream_decoder_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [3:0]  ext_hi;
    logic [3:0]  ext_lo;
    int unsigned target;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cur_skip = lsd_pkg::HEADER_SKIP_RST;
    cur_m0   = lsd_pkg::MAGIC_FIRST_RST;
    cur_m1   = lsd_pkg::MAGIC_SECOND_RST;
    cur_ext  = lsd_pkg::EXTENSION_CHARS_RST;

    // straight after reset, no image start flag
    build_image(cur_m0, cur_m1, 32'h0000_0000, 32'd2, 2);
    send_image(1'b0, WHOLE_IMAGE);
    // bad first magic byte, then bad second one, then ignored words
    build_image(8'h00, cur_m1, 32'd0, 32'd0, 0);
    send_image(1'b1, WHOLE_IMAGE);
    build_image(cur_m0, 8'hFF, 32'd0, 32'd0, 0);
    send_image(1'b1, WHOLE_IMAGE);
    push_noise(4);
    // no header, no extension characters, empty file
    set_config(8'd0, 8'hFF, 8'h00, 8'hF0);
    build_image(8'hFF, 8'h00, 32'hFFFF_FFFF, 32'd0, 0);
    send_image(1'b1, WHOLE_IMAGE);
    // longest header, extension count above the cap
    set_config(8'd255, 8'h00, 8'hFF, 8'h0F);
    build_image(8'h00, 8'hFF, $urandom, 32'd1, 1);
    send_image(1'b1, WHOLE_IMAGE);
    // restart in the middle of a huge file, then inside the header
    set_config(8'd3, 8'h5A, 8'hA5, 8'h01);
    build_image(cur_m0, cur_m1, $urandom, 32'hFFFF_FFFF, 3);
    send_image(1'b1, WHOLE_IMAGE);
    build_image(cur_m0, cur_m1, $urandom, 32'd2, 2);
    send_image(1'b1, 2);
    build_image(cur_m0, cur_m1, $urandom, 32'd3, 3);
    send_image(1'b1, WHOLE_IMAGE);
    push_noise(5);
    drain();

    // random images under a series of register settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(8'd0, 8'hFF, 8'h00, 8'h08);
        1: set_config(8'd255, 8'h00, 8'hFF, 8'hFF);
        2: set_config(lsd_pkg::HEADER_SKIP_RST, lsd_pkg::MAGIC_FIRST_RST,
                      lsd_pkg::MAGIC_SECOND_RST, {4'hA, lsd_pkg::EXTENSION_CHARS_RST});
        default: begin
          ext_hi = 4'($urandom_range(0, 15));
          ext_lo = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
          set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), {ext_hi, ext_lo});
        end
      endcase
      target = parsed_bytes + PHASE_ITEMS;
      while (parsed_bytes < target) random_image();
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("lsb_stego_stream_decoder_top verification clean");
    end else begin
      $display("lsb_stego_stream_decoder_top verification failed");
    end
    $finish;
  end

endmodule
